FILE: hdl/hsv2rgb_pkg.sv
// Constants, types and helper functions for the HSV to RGB converter.
// Used by hsv_to_rgb_converter; depends on nothing else.
package hsv2rgb_pkg;

  localparam int unsigned OneQ12    = 4096;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned OneX60    = OneQ12 * SectorDeg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned LevelW = 13;
  localparam int unsigned SecW   = 4;
  localparam int unsigned FracW  = 6;
  localparam int unsigned ProdW  = 18;
  localparam int unsigned OutW   = 8;

  // Reciprocal of 15 for dividends below 2**16: floor(n * RecipM15 / 2**RecipK15).
  localparam int unsigned RecipK15 = 20;
  localparam logic [16:0] RecipM15 = 17'(((1 << RecipK15) + 14) / 15);

  localparam logic [LevelW-1:0] LevelOne   = LevelW'(OneQ12);
  localparam logic [ProdW-1:0]  ProdOne    = ProdW'(OneX60);
  localparam logic [OutW-1:0]   MaxLevelRst = OutW'(255);

  typedef logic [SecW-1:0]   sector_t;
  typedef logic [FracW-1:0]  frac_t;
  typedef logic [LevelW-1:0] level_t;

  // Sector index of a hue: number of 60 degree marks at or below it.
  function automatic sector_t hue_sector(input logic [HueW-1:0] hue);
    sector_t sec;
    sec = '0;
    for (int i = 1; i <= 8; i++) begin
      if (hue >= HueW'(i * SectorDeg)) begin
        sec = SecW'(i);
      end
    end
    return sec;
  endfunction

  // First hue of a sector.
  function automatic logic [HueW-1:0] sector_base(input sector_t sec);
    logic [HueW-1:0] base;
    unique case (sec)
      4'd0:    base = HueW'(0);
      4'd1:    base = HueW'(60);
      4'd2:    base = HueW'(120);
      4'd3:    base = HueW'(180);
      4'd4:    base = HueW'(240);
      4'd5:    base = HueW'(300);
      4'd6:    base = HueW'(360);
      4'd7:    base = HueW'(420);
      4'd8:    base = HueW'(480);
      default: base = HueW'(0);
    endcase
    return base;
  endfunction

  function automatic level_t sat_level(input level_t x);
    return (x > LevelOne) ? LevelOne : x;
  endfunction

endpackage

FILE: hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter: four-stage pipeline from hue/value/saturation to scaled RGB.
// Depends on hsv2rgb_pkg.
//
//   channel  signals                                           direction
//   input    in_valid, in_stall, hue_degrees, value_level,
//            saturation_level                                  in (in_stall out)
//   output   out_valid, out_stall, red_level, green_level,
//            blue_level                                        out (out_stall in)
//   config   cfg_we, cfg_data (max_level)                      in
//
// One item per clock while out_stall does not hold the output; four register stages
// (sector and helper products, value products, divide by 60, output scaling).
// Reset clears the stage valid bits and sets max_level to 255.
// A stalled item at the output holds every stage; in_stall follows it.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HueW-1:0]  hue_degrees,
  input  logic [LevelW-1:0] value_level,
  input  logic [LevelW-1:0] saturation_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OutW-1:0]  red_level,
  output logic [OutW-1:0]  green_level,
  output logic [OutW-1:0]  blue_level,
  input  logic             cfg_we,
  input  logic [OutW-1:0]  cfg_data
);

  logic [OutW-1:0] max_level;
  logic            advance;

  logic            valid1, valid2, valid3;
  sector_t         sector1, sector2, sector3;
  level_t          v1, v2, v3;
  level_t          s1;
  logic [ProdW-1:0] sf1, sg1;
  logic [25:0]     pp2;
  logic [30:0]     pq2, pt2;
  level_t          p3, q3, t3;

  sector_t         sector_in;
  frac_t           frac_in;
  level_t          v_in, s_in;
  logic [HueW-1:0] frac_wide;
  logic [15:0]     q_quarter, t_quarter;
  logic [32:0]     q_recip, t_recip;
  level_t          r_sel, g_sel, b_sel;
  logic [20:0]     r_scaled, g_scaled, b_scaled;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level <= MaxLevelRst;
    end else if (cfg_we) begin
      max_level <= cfg_data;
    end
  end

  // Stage 1: sector, fraction, saturated inputs, saturation times fraction and times 60 minus fraction.
  always_comb begin
    sector_in = hue_sector(hue_degrees);
    frac_wide = hue_degrees - sector_base(sector_in);
    frac_in   = frac_wide[FracW-1:0];
    v_in      = sat_level(value_level);
    s_in      = sat_level(saturation_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sector1 <= sector_in;
      v1      <= v_in;
      s1      <= s_in;
      sf1     <= ProdW'(s_in * frac_in);
      sg1     <= ProdW'(s_in * (FracW'(SectorDeg) - frac_in));
    end
  end

  // Stage 2: value products.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (advance) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sector2 <= sector1;
      v2      <= v1;
      pp2     <= 26'(v1 * (LevelOne - s1));
      pq2     <= 31'(v1 * (ProdOne - sf1));
      pt2     <= 31'(v1 * (ProdOne - sg1));
    end
  end

  // Stage 3: divide by 4096 and by 60 (shift by 14, then reciprocal of 15).
  always_comb begin
    q_quarter = pq2[29:14];
    t_quarter = pt2[29:14];
    q_recip   = 33'(q_quarter * RecipM15);
    t_recip   = 33'(t_quarter * RecipM15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (advance) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sector3 <= sector2;
      v3      <= v2;
      p3      <= pp2[24:12];
      q3      <= q_recip[32:20];
      t3      <= t_recip[32:20];
    end
  end

  // Stage 4: sector assignment and output scaling.
  always_comb begin
    unique case (sector3)
      4'd1: begin
        r_sel = q3; g_sel = v3; b_sel = p3;
      end
      4'd2: begin
        r_sel = p3; g_sel = v3; b_sel = t3;
      end
      4'd3: begin
        r_sel = p3; g_sel = q3; b_sel = v3;
      end
      4'd4: begin
        r_sel = t3; g_sel = p3; b_sel = v3;
      end
      4'd5: begin
        r_sel = v3; g_sel = p3; b_sel = q3;
      end
      default: begin
        r_sel = v3; g_sel = t3; b_sel = p3;
      end
    endcase
    r_scaled = 21'(r_sel * max_level);
    g_scaled = 21'(g_sel * max_level);
    b_scaled = 21'(b_sel * max_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red_level   <= r_scaled[19:12];
      green_level <= g_scaled[19:12];
      blue_level  <= b_scaled[19:12];
    end
  end

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    valid3 && !in_stall |=> out_valid)
    else $error("item lost between stage 3 and output");

  a_in_to_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> valid1)
    else $error("accepted item missing in stage 1");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    valid1 |-> (v1 <= LevelOne) && (s1 <= LevelOne))
    else $error("saturated level above one");

endmodule
